// ----- rtl/core/grcer_pkg.sv -----
// Shared codes, field widths, command/status structs and the sine table function
package grcer_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [1:0] CELL_OCC = 2'd1;
    localparam logic [1:0] CELL_UNK = 2'd2;

    localparam logic [1:0] HIT_OCC  = 2'd0;
    localparam logic [1:0] HIT_UNK  = 2'd1;
    localparam logic [1:0] HIT_NONE = 2'd2;

    localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_MAX_STEPS  = 2'd2;

    localparam int CFG_W     = 10;
    localparam int CELL_W    = 9;
    localparam int COORD_W   = 20;
    localparam int ANGLE_W   = 16;
    localparam int TRIG_W    = 15;
    localparam int RANGE_W   = 10;

    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
    localparam logic [63:0] ONE_Q30    = 64'd1 << 30;
    localparam logic [63:0] SINE_MAX   = 64'd16384;

    typedef struct packed {
        logic load;
        logic write_cell;
        logic rom_cos;
        logic take_sin;
        logic take_trig;
        logic issue;
        logic march;
        logic flush;
    } grcer_cmd_t;

    typedef struct packed {
        logic issue_done;
        logic hit;
        logic pipe_empty;
    } grcer_sts_t;

    // Q14 sine of j / 2^table_bits of a turn, j in 0 .. quarter; elaboration only
    function automatic logic [TRIG_W-1:0] quarter_sine(input int j, input int table_bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(j) * TWO_PI_Q30) >> table_bits;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + (64'd1 << 15)) >> 16;
        if (s > SINE_MAX)
        begin
            s = SINE_MAX;
        end
        return TRIG_W'(s);
    endfunction

endpackage

// ----- rtl/core/grid_ray_cast_expected_range.sv -----
// Top level of the occupancy-grid ray caster: configuration registers, control and datapath
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------------------
//  command   | start / busy               | command, cell_x, cell_y, cell_code, laser_x,
//            |                            | laser_y, ray_angle, scan_end_in
//  config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//  result    | done (one-cycle strobe)    | hit_kind, range_steps, end_x, end_y,
//            |                            | scan_end_out
//
// A grid write gives no result; busy stays low.
// A cast steps through the sine table states S_SIN, S_COS and S_TRIG, then marches one
// step per cycle with one grid RAM read each, a four-stage drain and a report. A hit ends
// the march early; zero steps issues no step before the report.
// Reset clears control state and restores the configuration defaults; the grid is not cleared.
// Results are strobed by done for one cycle and cannot be held off.
module grid_ray_cast_expected_range #(
    parameter int MAP_X_BITS      = 9,
    parameter int MAP_Y_BITS      = 9,
    parameter int STEP_BITS       = 10,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  command,
    input  logic [grcer_pkg::CELL_W-1:0]          cell_x,
    input  logic [grcer_pkg::CELL_W-1:0]          cell_y,
    input  logic [1:0]                            cell_code,
    input  logic signed [grcer_pkg::COORD_W-1:0]  laser_x,
    input  logic signed [grcer_pkg::COORD_W-1:0]  laser_y,
    input  logic [grcer_pkg::ANGLE_W-1:0]         ray_angle,
    input  logic                                  scan_end_in,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [grcer_pkg::CFG_W-1:0]           cfg_data,
    output logic                                  done,
    output logic [1:0]                            hit_kind,
    output logic [grcer_pkg::RANGE_W-1:0]         range_steps,
    output logic signed [grcer_pkg::COORD_W-1:0]  end_x,
    output logic signed [grcer_pkg::COORD_W-1:0]  end_y,
    output logic                                  scan_end_out
);

    logic [grcer_pkg::CFG_W-1:0] map_width_reg, map_height_reg, max_steps_reg;
    grcer_pkg::grcer_cmd_t       cmd;
    grcer_pkg::grcer_sts_t       sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= grcer_pkg::CFG_W'(512);
            map_height_reg <= grcer_pkg::CFG_W'(512);
            max_steps_reg  <= grcer_pkg::CFG_W'(200);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                grcer_pkg::CFG_MAP_WIDTH:  map_width_reg  <= cfg_data;
                grcer_pkg::CFG_MAP_HEIGHT: map_height_reg <= cfg_data;
                grcer_pkg::CFG_MAX_STEPS:  max_steps_reg  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    grcer_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd),
        .sts     (sts)
    );

    grcer_datapath #(
        .MAP_X_BITS      (MAP_X_BITS),
        .MAP_Y_BITS      (MAP_Y_BITS),
        .STEP_BITS       (STEP_BITS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cell_x           (cell_x),
        .cell_y           (cell_y),
        .cell_code        (cell_code),
        .laser_x          (laser_x),
        .laser_y          (laser_y),
        .ray_angle        (ray_angle),
        .scan_end_in      (scan_end_in),
        .map_width_cells  (map_width_reg),
        .map_height_cells (map_height_reg),
        .max_steps        (max_steps_reg),
        .hit_kind         (hit_kind),
        .range_steps      (range_steps),
        .end_x            (end_x),
        .end_y            (end_y),
        .scan_end_out     (scan_end_out)
    );

endmodule

// ----- rtl/core/grcer_ram.sv -----
// Generic simple dual-port RAM, one write port, one registered read port
module grcer_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 262144
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/grcer_sine_rom.sv -----
// Quarter-wave Q14 sine table with registered read
module grcer_sine_rom #(
    parameter int TABLE_BITS = 10
) (
    input  logic                          clk,
    input  logic [TABLE_BITS-2:0]         addr,
    output logic [grcer_pkg::TRIG_W-1:0]  data
);

    localparam int QUARTER = 2 ** (TABLE_BITS - 2);

    logic [grcer_pkg::TRIG_W-1:0] rom_val [QUARTER+1];
    logic [grcer_pkg::TRIG_W-1:0] data_reg;

    for (genvar i = 0; i <= QUARTER; i++)
    begin : g_rom
        assign rom_val[i] = grcer_pkg::quarter_sine(i, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= rom_val[addr];
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/grcer_datapath.sv -----
// Ray caster datapath: trig setup, step accumulators, rounding pipeline, grid lookup
module grcer_datapath #(
    parameter int MAP_X_BITS      = 9,
    parameter int MAP_Y_BITS      = 9,
    parameter int STEP_BITS       = 10,
    parameter int SINE_TABLE_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  grcer_pkg::grcer_cmd_t                 cmd,
    output grcer_pkg::grcer_sts_t                 sts,
    input  logic [grcer_pkg::CELL_W-1:0]          cell_x,
    input  logic [grcer_pkg::CELL_W-1:0]          cell_y,
    input  logic [1:0]                            cell_code,
    input  logic signed [grcer_pkg::COORD_W-1:0]  laser_x,
    input  logic signed [grcer_pkg::COORD_W-1:0]  laser_y,
    input  logic [grcer_pkg::ANGLE_W-1:0]         ray_angle,
    input  logic                                  scan_end_in,
    input  logic [grcer_pkg::CFG_W-1:0]           map_width_cells,
    input  logic [grcer_pkg::CFG_W-1:0]           map_height_cells,
    input  logic [grcer_pkg::CFG_W-1:0]           max_steps,
    output logic [1:0]                            hit_kind,
    output logic [grcer_pkg::RANGE_W-1:0]         range_steps,
    output logic signed [grcer_pkg::COORD_W-1:0]  end_x,
    output logic signed [grcer_pkg::COORD_W-1:0]  end_y,
    output logic                                  scan_end_out
);

    localparam int ADDR_W     = MAP_X_BITS + MAP_Y_BITS;
    localparam int GRID_DEPTH = 2 ** ADDR_W;
    localparam int QUARTER    = 2 ** (SINE_TABLE_BITS - 2);
    localparam int ROM_AW     = SINE_TABLE_BITS - 1;
    localparam int M_W        = SINE_TABLE_BITS - 2;
    localparam int MAX_STEP   = 2 ** STEP_BITS - 1;
    localparam int TW         = grcer_pkg::TRIG_W;
    localparam int CW         = grcer_pkg::COORD_W;
    localparam int ACC_W      = STEP_BITS + 15;
    localparam int OFF_W      = ACC_W - 6;
    localparam int PX_W       = ((OFF_W > CW) ? OFF_W : CW) + 1;
    localparam int IX_W       = PX_W - 8;

    // cast setup
    logic signed [CW-1:0]     lx_reg, ly_reg;
    logic [1:0]               quad_reg;
    logic [M_W-1:0]           m_reg;
    logic [STEP_BITS-1:0]     steps_reg;
    logic [grcer_pkg::CFG_W-1:0] w_reg, h_reg;
    logic [TW-1:0]            sm_reg;
    logic signed [TW:0]       c_reg, s_reg;
    logic [STEP_BITS-1:0]     steps_eff;

    // trig table
    logic [ROM_AW-1:0]        rom_addr;
    logic [TW-1:0]            rom_data;
    logic signed [TW:0]       sm_s, sc_s;

    // march pipeline
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;
    logic [STEP_BITS-1:0]     r_reg, r2_reg, r3_reg, r4_reg;
    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic [ACC_W-1:0]         rnd_x, rnd_y;
    logic signed [OFF_W-1:0]  off_x_reg, off_y_reg;
    logic signed [PX_W-1:0]   px_x_reg, px_y_reg;
    logic [PX_W-1:0]          pr_x, pr_y;
    logic [IX_W-1:0]          ix, iy;
    logic                     in_x, in_y;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [PX_W-1:0]   px4_x_reg, px4_y_reg;
    logic                     inside4_reg;
    logic [1:0]               code;
    logic                     hit;

    // result
    logic [1:0]                     kind_reg;
    logic [grcer_pkg::RANGE_W-1:0]  range_reg;
    logic signed [CW-1:0]           ex_reg, ey_reg;
    logic                           scan_reg;

    assign steps_eff = (32'(max_steps) > 32'(MAX_STEP)) ? STEP_BITS'(MAX_STEP)
                                                        : STEP_BITS'(max_steps);

    assign rom_addr = cmd.rom_cos ? (ROM_AW'(QUARTER) - ROM_AW'(m_reg)) : ROM_AW'(m_reg);

    grcer_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    assign sm_s = $signed({1'b0, sm_reg});
    assign sc_s = $signed({1'b0, rom_data});

    // half away from zero: add half, one less when negative, then drop bits
    assign rnd_x = $unsigned(acc_x_reg) + (acc_x_reg[ACC_W-1] ? ACC_W'(31) : ACC_W'(32));
    assign rnd_y = $unsigned(acc_y_reg) + (acc_y_reg[ACC_W-1] ? ACC_W'(31) : ACC_W'(32));
    assign pr_x  = $unsigned(px_x_reg) + (px_x_reg[PX_W-1] ? PX_W'(127) : PX_W'(128));
    assign pr_y  = $unsigned(px_y_reg) + (px_y_reg[PX_W-1] ? PX_W'(127) : PX_W'(128));
    assign ix    = pr_x[PX_W-1:8];
    assign iy    = pr_y[PX_W-1:8];

    assign in_x = !ix[IX_W-1] && (ix < IX_W'(w_reg)) && ((ix >> MAP_X_BITS) == '0);
    assign in_y = !iy[IX_W-1] && (iy < IX_W'(h_reg)) && ((iy >> MAP_Y_BITS) == '0);
    assign rd_addr = {iy[MAP_Y_BITS-1:0], ix[MAP_X_BITS-1:0]};

    grcer_ram #(
        .WIDTH (2),
        .DEPTH (GRID_DEPTH)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (cmd.write_cell),
        .wr_addr ({MAP_Y_BITS'(cell_y), MAP_X_BITS'(cell_x)}),
        .wr_data (cell_code),
        .rd_en   (v3_reg),
        .rd_addr (rd_addr),
        .rd_data (code)
    );

    assign hit = v4_reg && inside4_reg
                 && ((code == grcer_pkg::CELL_OCC) || (code == grcer_pkg::CELL_UNK));

    assign sts.hit        = hit;
    assign sts.issue_done = (r_reg == steps_reg);
    assign sts.pipe_empty = !(v1_reg || v2_reg || v3_reg || v4_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            r_reg  <= '0;
        end
        else if (cmd.load || cmd.flush)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            r_reg  <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.issue)
            begin
                r_reg <= r_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lx_reg    <= laser_x;
            ly_reg    <= laser_y;
            quad_reg  <= ray_angle[grcer_pkg::ANGLE_W-1 -: 2];
            m_reg     <= ray_angle[grcer_pkg::ANGLE_W-3 -: M_W];
            steps_reg <= steps_eff;
            w_reg     <= map_width_cells;
            h_reg     <= map_height_cells;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            kind_reg  <= grcer_pkg::HIT_NONE;
            range_reg <= grcer_pkg::RANGE_W'(steps_eff);
            ex_reg    <= '0;
            ey_reg    <= '0;
            scan_reg  <= scan_end_in;
        end
        else if (cmd.issue)
        begin
            acc_x_reg <= acc_x_reg + ACC_W'(c_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(s_reg);
        end

        if (cmd.take_sin)
        begin
            sm_reg <= rom_data;
        end

        if (cmd.take_trig)
        begin
            case (quad_reg)
                2'd0:
                begin
                    c_reg <= sc_s;
                    s_reg <= sm_s;
                end
                2'd1:
                begin
                    c_reg <= -sm_s;
                    s_reg <= sc_s;
                end
                2'd2:
                begin
                    c_reg <= -sc_s;
                    s_reg <= -sm_s;
                end
                default:
                begin
                    c_reg <= sm_s;
                    s_reg <= -sc_s;
                end
            endcase
        end

        off_x_reg   <= $signed(rnd_x[ACC_W-1:6]);
        off_y_reg   <= $signed(rnd_y[ACC_W-1:6]);
        r2_reg      <= r_reg;
        px_x_reg    <= PX_W'(lx_reg) + PX_W'(off_x_reg);
        px_y_reg    <= PX_W'(ly_reg) + PX_W'(off_y_reg);
        r3_reg      <= r2_reg;
        px4_x_reg   <= px_x_reg;
        px4_y_reg   <= px_y_reg;
        inside4_reg <= in_x && in_y;
        r4_reg      <= r3_reg;

        if (cmd.march && hit)
        begin
            if (code == grcer_pkg::CELL_OCC)
            begin
                kind_reg  <= grcer_pkg::HIT_OCC;
                range_reg <= grcer_pkg::RANGE_W'(r4_reg);
            end
            else
            begin
                kind_reg  <= grcer_pkg::HIT_UNK;
                range_reg <= grcer_pkg::RANGE_W'(steps_reg);
            end
            ex_reg <= px4_x_reg[CW-1:0];
            ey_reg <= px4_y_reg[CW-1:0];
        end
    end

    assign hit_kind     = kind_reg;
    assign range_steps  = range_reg;
    assign end_x        = ex_reg;
    assign end_y        = ey_reg;
    assign scan_end_out = scan_reg;

endmodule

// ----- rtl/core/grcer_ctrl.sv -----
// Ray caster controller: accepts commands, sequences trig setup, march and report
module grcer_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   command,
    output logic                   busy,
    output logic                   done,
    output grcer_pkg::grcer_cmd_t  cmd,
    input  grcer_pkg::grcer_sts_t  sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIN,
        S_COS,
        S_TRIG,
        S_MARCH,
        S_REPORT
    } state_t;

    state_t state_reg, state_next;
    logic   busy_reg, done_reg;
    logic   cast_go, write_go;

    assign cast_go  = start && !busy_reg && (command == grcer_pkg::CMD_CAST);
    assign write_go = start && !busy_reg && (command == grcer_pkg::CMD_WRITE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cast_go)
                begin
                    state_next = S_SIN;
                end
            end
            S_SIN:
            begin
                state_next = S_COS;
            end
            S_COS:
            begin
                state_next = S_TRIG;
            end
            S_TRIG:
            begin
                state_next = S_MARCH;
            end
            S_MARCH:
            begin
                if (sts.hit || (sts.issue_done && sts.pipe_empty))
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.load       = cast_go;
        cmd.write_cell = write_go;
        cmd.rom_cos    = (state_reg == S_COS);
        cmd.take_sin   = (state_reg == S_COS);
        cmd.take_trig  = (state_reg == S_TRIG);
        cmd.march      = (state_reg == S_MARCH);
        cmd.issue      = (state_reg == S_MARCH) && !sts.issue_done && !sts.hit;
        cmd.flush      = (state_reg == S_REPORT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_REPORT);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("still busy after result beat");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == grcer_pkg::CMD_CAST)) |=> (busy && !done))
        else $error("cast not started");
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == grcer_pkg::CMD_WRITE)) |=> (!busy && !done))
        else $error("grid write produced activity");
`endif

endmodule
